FILE: hw/rtl/cau_pkg.sv
// Shared types and constants for the complex arithmetic unit.
`default_nettype none
package cau_pkg;

    localparam int WORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 16;

    typedef enum logic [1:0] {
        CMD_ADD = 2'd0,
        CMD_SUB = 2'd1,
        CMD_MUL = 2'd2,
        CMD_DIV = 2'd3
    } cau_cmd_t;

    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_OVF = 2'd1;
    localparam logic [1:0] STATUS_DZ  = 2'd2;

endpackage
`default_nettype wire

FILE: hw/rtl/cau_prod.sv
// First pipeline stage: all partial products and the add/subtract results.
`default_nettype none
module cau_prod #(
    parameter int WORD_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire cau_pkg::cau_cmd_t             in_cmd,
    input  wire logic signed [WORD_BITS-1:0]   a_real,
    input  wire logic signed [WORD_BITS-1:0]   a_imag,
    input  wire logic signed [WORD_BITS-1:0]   b_real,
    input  wire logic signed [WORD_BITS-1:0]   b_imag,
    output logic                               out_valid,
    output cau_pkg::cau_cmd_t                  out_cmd,
    output logic signed [2*WORD_BITS-1:0]      p_rr,
    output logic signed [2*WORD_BITS-1:0]      p_ii,
    output logic signed [2*WORD_BITS-1:0]      p_ri,
    output logic signed [2*WORD_BITS-1:0]      p_ir,
    output logic signed [2*WORD_BITS-1:0]      p_br2,
    output logic signed [2*WORD_BITS-1:0]      p_bi2,
    output logic signed [WORD_BITS:0]          as_re,
    output logic signed [WORD_BITS:0]          as_im
);
    import cau_pkg::*;

    localparam int P = 2 * WORD_BITS;

    logic signed [WORD_BITS:0] ar_e, ai_e, br_e, bi_e;

    assign ar_e = (WORD_BITS + 1)'(a_real);
    assign ai_e = (WORD_BITS + 1)'(a_imag);
    assign br_e = (WORD_BITS + 1)'(b_real);
    assign bi_e = (WORD_BITS + 1)'(b_imag);

    // Valid bit of the stage.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= in_valid;
        end
    end

    // Six full-width products and the sum or difference.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_cmd <= in_cmd;
            p_rr    <= P'(a_real) * P'(b_real);
            p_ii    <= P'(a_imag) * P'(b_imag);
            p_ri    <= P'(a_real) * P'(b_imag);
            p_ir    <= P'(a_imag) * P'(b_real);
            p_br2   <= P'(b_real) * P'(b_real);
            p_bi2   <= P'(b_imag) * P'(b_imag);
            as_re   <= (in_cmd == CMD_SUB) ? ar_e - br_e : ar_e + br_e;
            as_im   <= (in_cmd == CMD_SUB) ? ai_e - bi_e : ai_e + bi_e;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/cau_div_cell.sv
// One cell of the divider chain: produces one quotient bit for both parts.
`default_nettype none
module cau_div_cell #(
    parameter int DW   = 65,
    parameter int QB   = 33,
    parameter int SIDE = 72
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire logic [DW-1:0]   in_den,
    input  wire logic [DW-1:0]   in_rem_re,
    input  wire logic [DW-1:0]   in_rem_im,
    input  wire logic [QB-1:0]   in_nb_re,
    input  wire logic [QB-1:0]   in_nb_im,
    input  wire logic [QB-1:0]   in_q_re,
    input  wire logic [QB-1:0]   in_q_im,
    input  wire logic [SIDE-1:0] in_side,
    output logic                 out_valid,
    output logic [DW-1:0]        out_den,
    output logic [DW-1:0]        out_rem_re,
    output logic [DW-1:0]        out_rem_im,
    output logic [QB-1:0]        out_nb_re,
    output logic [QB-1:0]        out_nb_im,
    output logic [QB-1:0]        out_q_re,
    output logic [QB-1:0]        out_q_im,
    output logic [SIDE-1:0]      out_side
);
    logic [DW:0] tr_re, tr_im, dx;
    logic        ge_re, ge_im;

    // Bring down the next numerator bit and try the subtraction.
    assign dx    = {1'b0, in_den};
    assign tr_re = {in_rem_re, in_nb_re[QB-1]};
    assign tr_im = {in_rem_im, in_nb_im[QB-1]};
    assign ge_re = (tr_re >= dx);
    assign ge_im = (tr_im >= dx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid <= 1'b0;
        end
        else if (en)
        begin
            out_valid <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_den    <= in_den;
            out_rem_re <= DW'(ge_re ? tr_re - dx : tr_re);
            out_rem_im <= DW'(ge_im ? tr_im - dx : tr_im);
            out_nb_re  <= {in_nb_re[QB-2:0], 1'b0};
            out_nb_im  <= {in_nb_im[QB-2:0], 1'b0};
            out_q_re   <= {in_q_re[QB-2:0], ge_re};
            out_q_im   <= {in_q_im[QB-2:0], ge_im};
            out_side   <= in_side;
        end
    end

endmodule
`default_nettype wire

FILE: hw/rtl/complex_arith_unit.sv
// Top level of the complex arithmetic unit: add, subtract, multiply, divide.
//
//  Channel  | Direction | Handshake          | Payload
//  ---------+-----------+--------------------+--------------------------------
//  s_       | in        | s_tvalid/s_tready  | tdata: operands, tuser: cmd
//  m_       | out       | m_tvalid/m_tready  | tdata: result, tuser: status
//
// One operand pair is taken per cycle while s_tready is high. Every item,
// whatever its command, runs through the same pipeline: products, sums,
// range checks, one divider cell per quotient bit, then the output register.
// The divider chain of WORD_BITS+1 cells sets the latency.
// Reset clears only the valid bits. A skid register behind the output
// register holds one result while m_tready is low; the pipeline stalls only
// when that register is full.
`default_nettype none
module complex_arith_unit #(
    parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // a_real, a_imag, b_real, b_imag from the lowest bit up
    input  wire logic [((4*WORD_BITS+7)/8)*8-1:0]     s_tdata,
    // cmd
    input  wire logic [1:0]                           s_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    // res_real, res_imag from the lowest bit up
    output logic [((2*WORD_BITS+7)/8)*8-1:0]          m_tdata,
    // status
    output logic [1:0]                                m_tuser
);
    import cau_pkg::*;

    localparam int W    = WORD_BITS;
    localparam int F    = FRAC_BITS;
    localparam int P    = 2 * W;
    localparam int DW   = 2 * W + 1;
    localparam int NW   = DW + F;
    localparam int QB   = W + 1;
    localparam int CW   = DW + QB + NW;
    localparam int SIDE = 2 + 2 * W + 1 + 5;
    localparam int OUTB = ((2 * W + 7) / 8) * 8;

    localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

    logic en;

    // ---------------------------------------------------------------
    // Stage 1: products.
    logic                  s1_valid;
    cau_cmd_t              s1_cmd;
    logic signed [P-1:0]   p_rr, p_ii, p_ri, p_ir, p_br2, p_bi2;
    logic signed [W:0]     as_re, as_im;

    cau_prod #(
        .WORD_BITS(W)
    ) u_prod (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (s_tvalid),
        .in_cmd   (cau_cmd_t'(s_tuser)),
        .a_real   (s_tdata[W-1:0]),
        .a_imag   (s_tdata[2*W-1:W]),
        .b_real   (s_tdata[3*W-1:2*W]),
        .b_imag   (s_tdata[4*W-1:3*W]),
        .out_valid(s1_valid),
        .out_cmd  (s1_cmd),
        .p_rr     (p_rr),
        .p_ii     (p_ii),
        .p_ri     (p_ri),
        .p_ir     (p_ir),
        .p_br2    (p_br2),
        .p_bi2    (p_bi2),
        .as_re    (as_re),
        .as_im    (as_im)
    );

    // ---------------------------------------------------------------
    // Stage 2: sums of products, numerator magnitudes and the divisor.
    logic signed [DW-1:0] mul_re, mul_im, dn_re, dn_im, den_s;

    assign mul_re = DW'(p_rr) - DW'(p_ii);
    assign mul_im = DW'(p_ri) + DW'(p_ir);
    assign dn_re  = DW'(p_rr) + DW'(p_ii);
    assign dn_im  = DW'(p_ir) - DW'(p_ri);
    assign den_s  = DW'(p_br2) + DW'(p_bi2);

    logic                 s2_valid;
    cau_cmd_t             s2_cmd;
    logic signed [DW-1:0] s2_mul_re, s2_mul_im;
    logic signed [W:0]    s2_as_re, s2_as_im;
    logic [DW-1:0]        s2_mag_re, s2_mag_im, s2_den;
    logic                 s2_neg_re, s2_neg_im;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid <= 1'b0;
        end
        else if (en)
        begin
            s2_valid <= s1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_cmd    <= s1_cmd;
            s2_mul_re <= mul_re >>> F;
            s2_mul_im <= mul_im >>> F;
            s2_as_re  <= as_re;
            s2_as_im  <= as_im;
            s2_mag_re <= dn_re[DW-1] ? DW'(-dn_re) : DW'(dn_re);
            s2_mag_im <= dn_im[DW-1] ? DW'(-dn_im) : DW'(dn_im);
            s2_neg_re <= dn_re[DW-1];
            s2_neg_im <= dn_im[DW-1];
            s2_den    <= DW'(den_s);
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: quotient range check, divider seed, saturation of the
    // non-dividing results.
    logic [NW-1:0]   sh_re, sh_im;
    logic [CW-1:0]   den_top;
    logic            big_re, big_im, dz;
    logic signed [DW-1:0] ns_re_w, ns_im_w;
    logic [W-1:0]    ns_re, ns_im;
    logic            ns_ovf, fit_re, fit_im;

    assign sh_re   = {s2_mag_re, {F{1'b0}}};
    assign sh_im   = {s2_mag_im, {F{1'b0}}};
    assign den_top = CW'(s2_den) << QB;
    assign big_re  = (CW'(sh_re) >= den_top);
    assign big_im  = (CW'(sh_im) >= den_top);
    assign dz      = (s2_den == '0);

    // Sign-extended result of the add, subtract or multiply path.
    always_comb
    begin
        if (s2_cmd == CMD_MUL)
        begin
            ns_re_w = s2_mul_re;
            ns_im_w = s2_mul_im;
        end
        else
        begin
            ns_re_w = DW'(s2_as_re);
            ns_im_w = DW'(s2_as_im);
        end
    end

    assign fit_re = (&ns_re_w[DW-1:W-1]) || !(|ns_re_w[DW-1:W-1]);
    assign fit_im = (&ns_im_w[DW-1:W-1]) || !(|ns_im_w[DW-1:W-1]);
    assign ns_re  = fit_re ? ns_re_w[W-1:0] : (ns_re_w[DW-1] ? MINV : MAXV);
    assign ns_im  = fit_im ? ns_im_w[W-1:0] : (ns_im_w[DW-1] ? MINV : MAXV);
    assign ns_ovf = !fit_re || !fit_im;

    logic              c_valid [0:QB];
    logic [DW-1:0]     c_den   [0:QB];
    logic [DW-1:0]     c_rre   [0:QB];
    logic [DW-1:0]     c_rim   [0:QB];
    logic [QB-1:0]     c_nre   [0:QB];
    logic [QB-1:0]     c_nim   [0:QB];
    logic [QB-1:0]     c_qre   [0:QB];
    logic [QB-1:0]     c_qim   [0:QB];
    logic [SIDE-1:0]   c_side  [0:QB];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid[0] <= 1'b0;
        end
        else if (en)
        begin
            c_valid[0] <= s2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_den[0]  <= s2_den;
            c_rre[0]  <= DW'(sh_re >> QB);
            c_rim[0]  <= DW'(sh_im >> QB);
            c_nre[0]  <= sh_re[QB-1:0];
            c_nim[0]  <= sh_im[QB-1:0];
            c_qre[0]  <= '0;
            c_qim[0]  <= '0;
            c_side[0] <= {s2_cmd, ns_re, ns_im, ns_ovf, s2_neg_re, s2_neg_im,
                          big_re, big_im, dz};
        end
    end

    // ---------------------------------------------------------------
    // Divider chain, one quotient bit per cell.
    for (genvar i = 0; i < QB; i++)
    begin : g_cell
        cau_div_cell #(
            .DW  (DW),
            .QB  (QB),
            .SIDE(SIDE)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (c_valid[i]),
            .in_den    (c_den[i]),
            .in_rem_re (c_rre[i]),
            .in_rem_im (c_rim[i]),
            .in_nb_re  (c_nre[i]),
            .in_nb_im  (c_nim[i]),
            .in_q_re   (c_qre[i]),
            .in_q_im   (c_qim[i]),
            .in_side   (c_side[i]),
            .out_valid (c_valid[i+1]),
            .out_den   (c_den[i+1]),
            .out_rem_re(c_rre[i+1]),
            .out_rem_im(c_rim[i+1]),
            .out_nb_re (c_nre[i+1]),
            .out_nb_im (c_nim[i+1]),
            .out_q_re  (c_qre[i+1]),
            .out_q_im  (c_qim[i+1]),
            .out_side  (c_side[i+1])
        );
    end

    // ---------------------------------------------------------------
    // Final selection: sign and saturation of the quotients, and choice of result and status by command.
    cau_cmd_t      f_cmd;
    logic [W-1:0]  f_ns_re, f_ns_im;
    logic          f_ns_ovf, f_neg_re, f_neg_im, f_big_re, f_big_im, f_dz;
    logic [QB:0]   qs_re, qs_im;
    logic          qf_re, qf_im;
    logic [W-1:0]  dv_re, dv_im;
    logic [W-1:0]  r_re, r_im;
    logic [1:0]    r_st;

    assign {f_cmd, f_ns_re, f_ns_im, f_ns_ovf, f_neg_re, f_neg_im,
            f_big_re, f_big_im, f_dz} = c_side[QB];

    assign qs_re = f_neg_re ? -(QB+1)'(c_qre[QB]) : (QB+1)'(c_qre[QB]);
    assign qs_im = f_neg_im ? -(QB+1)'(c_qim[QB]) : (QB+1)'(c_qim[QB]);
    assign qf_re = !f_big_re && ((&qs_re[QB:W-1]) || !(|qs_re[QB:W-1]));
    assign qf_im = !f_big_im && ((&qs_im[QB:W-1]) || !(|qs_im[QB:W-1]));
    assign dv_re = qf_re ? qs_re[W-1:0] : (f_neg_re ? MINV : MAXV);
    assign dv_im = qf_im ? qs_im[W-1:0] : (f_neg_im ? MINV : MAXV);

    always_comb
    begin
        if (f_cmd != CMD_DIV)
        begin
            r_re = f_ns_re;
            r_im = f_ns_im;
            r_st = f_ns_ovf ? STATUS_OVF : STATUS_OK;
        end
        else if (f_dz)
        begin
            r_re = '0;
            r_im = '0;
            r_st = STATUS_DZ;
        end
        else
        begin
            r_re = dv_re;
            r_im = dv_im;
            r_st = (!qf_re || !qf_im) ? STATUS_OVF : STATUS_OK;
        end
    end

    // ---------------------------------------------------------------
    // Output register and skid register.
    logic          out_v_reg, skid_v_reg;
    logic [W-1:0]  out_re_reg, out_im_reg, skid_re_reg, skid_im_reg;
    logic [1:0]    out_st_reg, skid_st_reg;

    assign en       = !skid_v_reg;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (en)
        begin
            if (c_valid[QB])
            begin
                if (!out_v_reg || m_tready)
                begin
                    out_v_reg <= 1'b1;
                end
                else
                begin
                    skid_v_reg <= 1'b1;
                end
            end
            else if (m_tready)
            begin
                out_v_reg <= 1'b0;
            end
        end
        else if (m_tready)
        begin
            skid_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (c_valid[QB])
            begin
                if (!out_v_reg || m_tready)
                begin
                    out_re_reg <= r_re;
                    out_im_reg <= r_im;
                    out_st_reg <= r_st;
                end
                else
                begin
                    skid_re_reg <= r_re;
                    skid_im_reg <= r_im;
                    skid_st_reg <= r_st;
                end
            end
        end
        else if (m_tready)
        begin
            out_re_reg <= skid_re_reg;
            out_im_reg <= skid_im_reg;
            out_st_reg <= skid_st_reg;
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = OUTB'({out_im_reg, out_re_reg});
    assign m_tuser  = out_st_reg;

`ifndef SYNTHESIS
    // A held skid result implies a held output result.
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_v_reg |-> out_v_reg)
        else $error("skid register full while output register empty");

    // Status code three is never produced.
    a_status_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser != 2'd3))
        else $error("illegal status code on output");

    // A divide-by-zero result carries zero parts.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == STATUS_DZ) |-> (out_re_reg == '0 && out_im_reg == '0))
        else $error("divide-by-zero result with nonzero parts");

    // A result arriving at a stalled, full output register fills the skid register and blocks the input.
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && c_valid[QB] && out_v_reg) |=> !s_tready)
        else $error("input not stalled after skid fill");
`endif

endmodule
`default_nettype wire

FILE: verif/cau_checker.sv
// Checker for the complex arithmetic unit: predicts each result and compares it.
module cau_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic [127:0] s_tdata,
    input  wire logic [1:0]   s_tuser,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [63:0]  m_tdata,
    input  wire logic [1:0]   m_tuser,
    output int                fail_count,
    output int                pending
);
    import cau_pkg::*;

    typedef struct packed {
        logic [31:0] re;
        logic [31:0] im;
        logic [1:0]  status;
    } cplx_result_t;

    cplx_result_t result_queue[$];

    // Clamp a wide signed value to 32 bits and note any overflow.
    function automatic logic [31:0] clamp32(input logic signed [127:0] v, inout logic ovf);
        if (v > 128'sd2147483647) begin
            ovf = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -128'sd2147483648) begin
            ovf = 1'b1;
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    // Signed division truncating toward zero, divisor positive.
    function automatic logic signed [127:0] div_trunc(input logic signed [127:0] num,
                                                      input logic signed [127:0] den);
        logic [127:0] mag;
        logic [127:0] q;
        mag = num[127] ? -num : num;
        q = mag / den;
        return num[127] ? -q : q;
    endfunction

    function automatic cplx_result_t predict_complex_op(input cau_cmd_t op,
                                                        input logic [127:0] d);
        logic signed [127:0] ar, ai, br, bi, re, im, den;
        cplx_result_t r;
        logic ovf;
        ar = $signed(d[31:0]);
        ai = $signed(d[63:32]);
        br = $signed(d[95:64]);
        bi = $signed(d[127:96]);
        ovf = 1'b0;
        re = 0;
        im = 0;
        case (op)
            CMD_ADD: begin re = ar + br; im = ai + bi; end
            CMD_SUB: begin re = ar - br; im = ai - bi; end
            CMD_MUL: begin
                re = (ar * br - ai * bi) >>> 16;
                im = (ar * bi + ai * br) >>> 16;
            end
            default: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.re = '0;
                    r.im = '0;
                    r.status = STATUS_DZ;
                    return r;
                end
                re = div_trunc((ar * br + ai * bi) <<< 16, den);
                im = div_trunc((ai * br - ar * bi) <<< 16, den);
            end
        endcase
        r.re = clamp32(re, ovf);
        r.im = clamp32(im, ovf);
        r.status = ovf ? STATUS_OVF : STATUS_OK;
        return r;
    endfunction

    assign pending = result_queue.size();

    // Record each accepted operand transfer and check each result transfer.
    always @(posedge clk or negedge rst_n)
    begin
        cplx_result_t want;
        int errs;
        errs = 0;
        if (!rst_n) begin
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready)
                result_queue.push_back(predict_complex_op(cau_cmd_t'(s_tuser), s_tdata));
            if (m_tvalid && m_tready) begin
                if (result_queue.size() == 0) begin
                    $error("result transfer with no result expected");
                    errs++;
                end else begin
                    want = result_queue.pop_front();
                    if (m_tdata[31:0] !== want.re) begin
                        $error("res_real: expected %h, actual %h", want.re, m_tdata[31:0]);
                        errs++;
                    end
                    if (m_tdata[63:32] !== want.im) begin
                        $error("res_imag: expected %h, actual %h", want.im, m_tdata[63:32]);
                        errs++;
                    end
                    if (m_tuser !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_tuser);
                        errs++;
                    end
                end
            end
            if (errs != 0)
                fail_count <= fail_count + errs;
        end
    end

endmodule

FILE: verif/tb.sv
// Testbench top for the complex arithmetic unit: stimulus and final verdict.
module tb;
    import cau_pkg::*;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [127:0] s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [63:0]  m_tdata;
    logic [1:0]   m_tuser;
    int           fail_count;
    int           pending;
    bit           calm;

    complex_arith_unit dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    cau_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stalls at random, except during the calm stretch.
    always @(posedge clk)
    begin
        m_tready <= calm || ($urandom_range(99) >= 22);
    end

    // Pick an operand part: mostly random, often an extreme or small value.
    function automatic logic [31:0] pick_part();
        case ($urandom_range(7))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return $urandom_range(131072) - 65536;
            default: return $urandom;
        endcase
    endfunction

    // Present one operand transfer and hold it until accepted.
    task automatic send_op(input cau_cmd_t op, input logic [31:0] ar, input logic [31:0] ai,
                           input logic [31:0] br, input logic [31:0] bi, input bit gaps);
        while (gaps && !calm && $urandom_range(99) < 22) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {bi, br, ai, ar};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    initial
    begin
        logic [31:0] ex[4];
        int n;
        ex = '{32'h7fffffff, 32'h80000000, 32'h0, 32'h00010000};
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = CMD_ADD;
        calm     = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        // Directed: every operation on extremes, and division by zero.
        for (int op = 0; op < 4; op++)
        begin
            for (int k = 0; k < 4; k++)
                send_op(cau_cmd_t'(op), ex[k], ex[3 - k], ex[(k + 1) % 4], ex[k], 1'b0);
        end
        send_op(CMD_DIV, 32'h00030000, 32'hfffe0000, 32'h0, 32'h0, 1'b0);
        send_op(CMD_DIV, 32'h7fffffff, 32'h80000000, 32'h0, 32'h00000001, 1'b0);
        send_op(CMD_MUL, 32'h00020000, 32'hffff8000, 32'h00018000, 32'h00004000, 1'b0);
        send_op(CMD_DIV, 32'h00050000, 32'h00020000, 32'h00010000, 32'hffff0000, 1'b0);
        // Let the block drain completely before the random part.
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        // Random operations, with a calm stretch in the middle.
        for (n = 0; n < 600; n++)
        begin
            calm = (n >= 250 && n < 350);
            send_op(cau_cmd_t'($urandom_range(3)), pick_part(), pick_part(),
                    ($urandom_range(15) == 0) ? 32'h0 : pick_part(),
                    ($urandom_range(15) == 0) ? 32'h0 : pick_part(), 1'b1);
        end
        calm = 1'b0;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/cau_pkg.sv
hw/rtl/cau_prod.sv
hw/rtl/cau_div_cell.sv
hw/rtl/complex_arith_unit.sv
verif/cau_checker.sv
verif/tb.sv
